// ----- sv/csrmv_pkg.sv -----
// Shared types, codes and constants of the CSR sparse matrix-vector core.
// No dependencies; compiled first.
package csrmv_pkg;

	// item codes on the func field
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_NONZERO = 2'd1;
	localparam logic [1:0] FUNC_ROW_END = 2'd2;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned COL_W    = 10;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ROW_W    = 16;
	localparam int unsigned ACC_W    = 64;
	localparam int unsigned PROD_W   = 48;   // Q32.16 product after the 16-bit shift
	localparam int unsigned COL_SPAN = 1 << COL_W;

	localparam int unsigned MAX_COLUMNS_DEFAULT = 1024;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// one classified operation handed from front to back
	typedef struct packed {
		logic                     row_end;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] vec;
	} op_t;

endpackage

// ----- sv/csrmv_if.sv -----
// Valid/ready channel interfaces: input items and row results.
// Depends on csrmv_pkg for field widths.
interface csrmv_item_if;
	import csrmv_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [COL_W-1:0]         column;
	logic signed [DATA_W-1:0] value;
	modport source(output valid, func, column, value, input ready);
	modport sink(input valid, func, column, value, output ready);
endinterface

interface csrmv_sum_if;
	import csrmv_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] row_sum;
	logic [ROW_W-1:0]         row_number;
	logic                     last_row;
	logic                     saturated;
	modport source(output valid, row_sum, row_number, last_row, saturated, input ready);
	modport sink(input valid, row_sum, row_number, last_row, saturated, output ready);
endinterface

// ----- sv/csrmv_front.sv -----
// Front end: accepts items, owns the vector store, classifies work for the back end.
// Depends on csrmv_pkg and csrmv_if.
module csrmv_front #(
	parameter int unsigned MAX_COLUMNS = csrmv_pkg::MAX_COLUMNS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	csrmv_item_if.sink         in_ch,
	output logic               q_valid,
	input  logic               q_ready,
	output csrmv_pkg::op_t     q_op
);
	import csrmv_pkg::*;

	localparam int unsigned DEPTH  = (MAX_COLUMNS < COL_SPAN) ? MAX_COLUMNS : COL_SPAN;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [DATA_W-1:0] store_mem [DEPTH];

	logic                     valid_s1;
	logic                     row_end_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic [DATA_W-1:0]        vec_s1;

	logic              accept;
	logic              in_range;
	logic              keep;
	logic [ADDR_W-1:0] addr;

	assign in_ch.ready = !valid_s1 || q_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_range    = {1'b0, in_ch.column} < (COL_W+1)'(DEPTH);
	assign addr        = in_ch.column[ADDR_W-1:0];
	// loads and out-of-range or spare codes stop here
	assign keep        = accept && (((in_ch.func == FUNC_NONZERO) && in_range)
	                                || (in_ch.func == FUNC_ROW_END));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			row_end_s1 <= (in_ch.func == FUNC_ROW_END);
			value_s1   <= in_ch.value;
		end
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && (in_ch.func == FUNC_LOAD) && in_range) begin
			store_mem[addr] <= in_ch.value;
		end
		if (keep) begin
			vec_s1 <= store_mem[addr];
		end
	end

	assign q_valid      = valid_s1;
	assign q_op.row_end = row_end_s1;
	assign q_op.value   = value_s1;
	assign q_op.vec     = $signed(vec_s1);

endmodule

// ----- sv/csrmv_queue.sv -----
// Short FIFO between front and back end.
// Depends on csrmv_pkg for op_t.
module csrmv_queue #(
	parameter int unsigned DEPTH = csrmv_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  csrmv_pkg::op_t in_op,
	output logic           out_valid,
	input  logic           out_ready,
	output csrmv_pkg::op_t out_op
);
	import csrmv_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	op_t              entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_op;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue empty but pointers differ");

endmodule

// ----- sv/csrmv_back.sv -----
// Back end: multiply, saturating accumulate, row close-out and result register.
// Depends on csrmv_pkg and csrmv_if.
module csrmv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  csrmv_pkg::op_t                 q_op,
	input  logic [csrmv_pkg::ROW_W-1:0]    rows_in_use,
	csrmv_sum_if.source                    out_ch
);
	import csrmv_pkg::*;

	logic                     en;
	logic signed [ACC_W-1:0]  prod_full;
	logic signed [ACC_W-1:0]  prod_shift;

	logic                     valid_s2;
	logic                     row_end_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0]  acc_q;
	logic [ROW_W-1:0]         row_cnt_q;

	logic [ACC_W:0]           sum_wide;
	logic signed [ACC_W-1:0]  acc_next;
	logic                     clip_hi;
	logic                     clip_lo;
	logic [ROW_W:0]           limit;
	logic                     wrap;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] row_sum_q;
	logic [ROW_W-1:0]         row_number_q;
	logic                     last_row_q;
	logic                     saturated_q;

	// whole back end moves unless a result is waiting
	assign en      = !out_valid_q || out_ch.ready;
	assign q_ready = en;

	assign prod_full  = q_op.value * q_op.vec;
	assign prod_shift = prod_full >>> 16;   // floor

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && q_valid) begin
			row_end_s2 <= q_op.row_end;
			prod_s2    <= prod_shift[PROD_W-1:0];
		end
	end

	assign sum_wide = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign acc_next = (sum_wide[ACC_W] != sum_wide[ACC_W-1])
	                ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX)
	                : $signed(sum_wide[ACC_W-1:0]);

	assign clip_hi = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:DATA_W-1]);
	assign clip_lo = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:DATA_W-1]);

	// zero count means the full 16-bit range of rows
	assign limit = (rows_in_use == '0) ? {1'b1, {ROW_W{1'b0}}} : {1'b0, rows_in_use};
	assign wrap  = ({1'b0, row_cnt_q} + (ROW_W+1)'(1)) >= limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2 && row_end_s2;
			if (valid_s2) begin
				if (row_end_s2) begin
					acc_q     <= '0;
					row_cnt_q <= wrap ? '0 : row_cnt_q + 1'b1;
				end else begin
					acc_q <= acc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2 && row_end_s2) begin
			priority if (clip_hi) begin
				row_sum_q <= SUM_MAX;
			end else if (clip_lo) begin
				row_sum_q <= SUM_MIN;
			end else begin
				row_sum_q <= acc_q[DATA_W-1:0];
			end
			saturated_q  <= clip_hi || clip_lo;
			row_number_q <= row_cnt_q;
			last_row_q   <= row_cnt_q == (rows_in_use - ROW_W'(1));
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.row_sum    = row_sum_q;
	assign out_ch.row_number = row_number_q;
	assign out_ch.last_row   = last_row_q;
	assign out_ch.saturated  = saturated_q;

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s2 && row_end_s2) |=> (acc_q == '0))
		else $error("accumulator not cleared after row end");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && saturated_q) |-> (row_sum_q == SUM_MAX || row_sum_q == SUM_MIN))
		else $error("saturated flag without a clipped sum");

endmodule

// ----- sv/csr_sparse_matrix_vector_multiply_core.sv -----
// Top level of the CSR sparse matrix-vector core: config register and wiring.
// Depends on csrmv_pkg, csrmv_if, csrmv_front, csrmv_queue and csrmv_back.
//
//  channel    dir   handshake        carries
//  items      in    valid/ready      func, column, value
//  sums       out   valid/ready      row_sum, row_number, last_row, saturated
//  cfg        in    cfg_wr_en        cfg_wr_data -> rows_in_use
//
// One item per cycle sustained while no result is held: the store has one read
// and one write port and the back end does one multiply-accumulate per cycle.
// A row-end result passes the front register (store read at the edge that takes
// its item), the queue, the product register and the result register.
// Reset clears control state, the accumulator, the row counter and sets
// rows_in_use to 1; the vector store is not cleared and needs no sweep.
// A held result stalls only the back end; items keep arriving until the queue
// and the front register are full.
module csr_sparse_matrix_vector_multiply_core #(
	parameter int unsigned MAX_COLUMNS = csrmv_pkg::MAX_COLUMNS_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = csrmv_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	csrmv_item_if.sink                  items,
	csrmv_sum_if.source                 sums,
	input  logic                        cfg_wr_en,
	input  logic [csrmv_pkg::ROW_W-1:0] cfg_wr_data
);
	import csrmv_pkg::*;

	logic [ROW_W-1:0] rows_in_use_q;

	// front -> queue
	logic f_valid;
	logic f_ready;
	op_t  f_op;
	// queue -> back
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	// rows_in_use: the user must write it only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= ROW_W'(1);
		end else if (cfg_wr_en) begin
			rows_in_use_q <= cfg_wr_data;
		end
	end

	// front: vector loads land in the store, nonzeros pick up their element
	csrmv_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (items),
		.q_valid(f_valid),
		.q_ready(f_ready),
		.q_op   (f_op)
	);

	csrmv_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_op    (f_op),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_op   (b_op)
	);

	// back: product, saturating sum, row close-out
	csrmv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (b_valid),
		.q_ready    (b_ready),
		.q_op       (b_op),
		.rows_in_use(rows_in_use_q),
		.out_ch     (sums)
	);

endmodule
